// ----- design/assert_macros.svh -----
// assertion helpers used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition that never holds outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- design/ssfd_pkg.sv -----
// ----------------------------------------------------------------------------
// ssfd_pkg
// shared types and constants of the serial stream format detector
// ----------------------------------------------------------------------------
package ssfd_pkg;

    localparam int MIN_BYTES_W = 13;
    localparam logic [MIN_BYTES_W-1:0] MIN_BYTES_RST = 13'd64;
    localparam int CONF_W = 17;
    localparam logic [31:0] TAIL_PATTERN = 32'h0000_807F;

    localparam logic [1:0] MODE_RAW   = 2'd0;
    localparam logic [1:0] MODE_FLOAT = 2'd1;
    localparam logic [1:0] MODE_TEXT  = 2'd2;

    localparam logic [2:0] OP_FLOAT = 3'd0;
    localparam logic [2:0] OP_PRINT = 3'd1;
    localparam logic [2:0] OP_SEP   = 3'd2;
    localparam logic [2:0] OP_NUM   = 3'd3;
    localparam logic [2:0] OP_TEXT  = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]        mode;
        logic [CONF_W-1:0] confidence;
        logic              detected;
        logic              truncated;
    } t_out;

    typedef struct packed {
        logic push;
        logic full;
    } t_q_wr;

endpackage

// ----- design/ssfd_front.sv -----
// ----------------------------------------------------------------------------
// ssfd_front
// per-byte classification, tail matching and buffer snapshot on the last byte
// ----------------------------------------------------------------------------
module ssfd_front #(
    parameter int MAX_BYTES = 4096,
    parameter int CW        = 13,
    parameter int SW        = 7 * CW + 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    output logic                             o_full,
    input  ssfd_pkg::t_in                    i_in,
    input  logic [ssfd_pkg::MIN_BYTES_W-1:0] i_min_bytes,
    output ssfd_pkg::t_q_wr                  o_q_wr,
    input  logic                             i_q_full,
    output logic [SW-1:0]                    o_snap
);
    import ssfd_pkg::*;

    localparam int MW = (CW > MIN_BYTES_W) ? CW : MIN_BYTES_W;

    logic [23:0]   r_prev, n_prev;
    logic [CW-1:0] r_n, n_n, r_tm, n_tm, r_am, n_am;
    logic [CW-1:0] r_nl, n_nl, r_sep, n_sep, r_num, n_num, r_pr, n_pr;
    logic          r_ovf, n_ovf;
    logic          take, in_range, is_match, det;
    logic [7:0]    b;
    logic [CW-1:0] sum;

    assign b        = i_in.data_byte;
    assign take     = i_push && !i_q_full;
    assign in_range = r_n < CW'(MAX_BYTES);
    assign is_match = (r_n >= CW'(3)) && ({r_prev, b} == TAIL_PATTERN);

    always_comb begin
        n_prev = r_prev; n_n = r_n; n_tm = r_tm; n_am = r_am;
        n_nl = r_nl; n_sep = r_sep; n_num = r_num; n_pr = r_pr; n_ovf = r_ovf;
        if (in_range) begin
            if (is_match) begin
                n_tm = r_tm + CW'(1);
                if (r_n[1:0] == 2'd3) n_am = r_am + CW'(1);
            end
            priority if (b == 8'h0A || b == 8'h0D) begin
                n_nl = r_nl + CW'(1);
            end else if (b == 8'h2C || b == 8'h09 || b == 8'h20) begin
                n_sep = r_sep + CW'(1);
            end else if ((b >= 8'h30 && b <= 8'h39) || b == 8'h2E || b == 8'h2D
                         || b == 8'h2B) begin
                n_num = r_num + CW'(1);
            end else if (b >= 8'h20 && b < 8'h7F) begin
                n_pr = r_pr + CW'(1);
            end
            n_prev = {r_prev[15:0], b};
            n_n    = r_n + CW'(1);
        end else begin
            n_ovf = 1'b1;
        end
    end

    assign sum = n_pr + n_nl + n_sep + n_num;
    assign det = MW'(n_n) >= MW'(i_min_bytes);
    assign o_snap = {n_ovf, det, n_n, n_tm, n_am, n_nl, n_sep, n_num, sum};
    assign o_full = i_q_full;
    assign o_q_wr = '{push: take && i_in.last_byte, full: i_q_full};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (take && i_in.last_byte)) begin
            r_prev <= '0; r_n <= '0; r_tm <= '0; r_am <= '0; r_nl <= '0;
            r_sep <= '0; r_num <= '0; r_pr <= '0; r_ovf <= 1'b0;
        end else if (take) begin
            r_prev <= n_prev; r_n <= n_n; r_tm <= n_tm; r_am <= n_am; r_nl <= n_nl;
            r_sep <= n_sep; r_num <= n_num; r_pr <= n_pr; r_ovf <= n_ovf;
        end
    end
endmodule

// ----- design/ssfd_queue.sv -----
// ----------------------------------------------------------------------------
// ssfd_queue
// two-entry queue of buffer snapshots between front and back
// ----------------------------------------------------------------------------
module ssfd_queue #(
    parameter int W = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ssfd_pkg::t_q_wr i_wr,
    input  logic [W-1:0]  i_data,
    output logic          o_full,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [W-1:0]  o_data
);
    import ssfd_pkg::*;

    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         wr, rd;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign wr      = i_wr.push && !i_wr.full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end
endmodule

// ----- design/ssfd_div.sv -----
// ----------------------------------------------------------------------------
// ssfd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ssfd_div #(
    parameter int NW = 32,
    parameter int CW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [CW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    import ssfd_pkg::*;

    localparam int KW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [CW-1:0] r_den, r_rem;
    logic [KW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [CW:0]   sh;
    logic          ge;

    assign sh     = {r_rem, r_q[NW-1]};
    assign ge     = sh >= {1'b0, r_den};
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num; r_den <= i_den; r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[NW-2:0], ge};
            r_rem <= ge ? CW'(sh - {1'b0, r_den}) : sh[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == KW'(1));
            if (i_start) begin
                r_busy <= 1'b1; r_cnt <= KW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - KW'(1);
                if (r_cnt == KW'(1)) r_busy <= 1'b0;
            end
        end
    end
endmodule

// ----- design/ssfd_back.sv -----
// ----------------------------------------------------------------------------
// ssfd_back
// score sequencer over a shared divider, verdict and result register
// ----------------------------------------------------------------------------
module ssfd_back #(
    parameter int CW = 13,
    parameter int FB = 16,
    parameter int SW = 7 * CW + 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    output logic           o_q_pop,
    input  logic [SW-1:0]  i_snap,
    output logic           o_empty,
    input  logic           i_pop,
    output ssfd_pkg::t_out o_out
);
    import ssfd_pkg::*;

    localparam int NW = CW + 3 + FB;
    localparam logic [NW-1:0] ONE  = NW'(1) << FB;
    localparam logic [NW-1:0] HALF = NW'(1) << (FB - 1);
    localparam int TW = FB + 4;
    localparam int RW = FB + 5;
    localparam int RK = FB + 8;
    localparam logic [RW-1:0] RECIP = RW'(((64'd1 << RK) + 64'd9) / 64'd10);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_LOAD = 5'b00010, S_DIV = 5'b00100, S_MUL = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state        r_st;
    logic [2:0]    r_op;
    logic [SW-1:0] r_snap;
    logic [NW-1:0] r_qa, r_qp, r_qs, r_qd, r_qt;
    logic [TW-1:0] r_tsum;
    logic          r_ov, n_ov;
    t_out          r_out;

    logic          ovf, det;
    logic [CW-1:0] n, tm, am, nl, sep, num, sum;
    logic [NW-1:0] num_v, s_c, d_c, l_v, fs, ts, mx, conf;
    logic [CW-1:0] den_v;
    logic          d_done, start, slot;
    logic [NW-1:0] quot;
    logic [TW+RW-1:0] prod;
    logic [1:0]    mode;

    assign {ovf, det, n, tm, am, nl, sep, num, sum} = r_snap;

    assign s_c = (r_qs > ONE) ? ONE : r_qs;
    assign d_c = (r_qd > ONE) ? ONE : r_qd;
    assign l_v = (nl >= CW'(2)) ? ONE : HALF;

    always_comb begin
        unique case (r_op)
            OP_PRINT: begin num_v = NW'(sum) << FB; den_v = n; end
            OP_SEP: begin
                num_v = (NW'(sep) << (FB + 2)) + (NW'(sep) << FB); den_v = n;
            end
            OP_NUM: begin
                num_v = (NW'(num) << (FB + 1)) + (NW'(num) << FB); den_v = n;
            end
            OP_TEXT: begin
                num_v = (r_qp << 1) + r_qp + (s_c << 1) + s_c + (d_c << 1) + (l_v << 1);
                den_v = n;
            end
            default: begin num_v = NW'(am) << FB; den_v = tm; end
        endcase
    end

    assign start = (r_st == S_LOAD) && (r_op != OP_TEXT);

    ssfd_div #(.NW(NW), .CW(CW)) u_div (
        .i_clk, .i_rst_n, .i_start(start), .i_num(num_v), .i_den(den_v),
        .o_done(d_done), .o_quot(quot)
    );

    // divide by ten through a reciprocal multiply
    assign prod = (TW+RW)'(r_tsum) * (TW+RW)'(RECIP);

    assign fs = (tm == '0) ? '0 : ((tm >= CW'(2)) ? r_qa : (r_qa >> 1));
    assign ts = (n == '0 || nl == '0) ? '0 : ((r_qt > ONE) ? ONE : r_qt);
    assign mx = (fs > ts) ? fs : ts;

    always_comb begin
        priority if (!det) begin
            mode = MODE_RAW; conf = '0;
        end else if (fs > ts && fs >= HALF) begin
            mode = MODE_FLOAT; conf = fs;
        end else if (ts >= HALF) begin
            mode = MODE_TEXT; conf = ts;
        end else begin
            mode = MODE_RAW; conf = ONE - mx;
        end
    end

    assign slot    = !r_ov || i_pop;
    assign n_ov    = (r_st == S_DONE && slot) ? 1'b1 : (r_ov && !i_pop);
    assign o_q_pop = (r_st == S_IDLE) && !i_q_empty;
    assign o_empty = !r_ov;
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_snap <= i_snap;
        if (r_st == S_DIV && d_done) begin
            unique case (r_op)
                OP_PRINT: r_qp <= quot;
                OP_SEP:   r_qs <= quot;
                OP_NUM:   r_qd <= quot;
                default:  r_qa <= quot;
            endcase
        end
        if (r_st == S_LOAD && r_op == OP_TEXT) r_tsum <= TW'(num_v);
        if (r_st == S_MUL) r_qt <= NW'(prod >> RK);
        if (r_st == S_DONE && slot) begin
            r_out <= '{mode: mode, confidence: CONF_W'(conf), detected: det,
                       truncated: ovf};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_op <= OP_FLOAT; r_ov <= 1'b0;
        end else begin
            r_ov <= n_ov;
            unique case (r_st)
                S_IDLE: if (!i_q_empty) begin
                    r_st <= S_LOAD; r_op <= OP_FLOAT;
                end
                S_LOAD: r_st <= (r_op == OP_TEXT) ? S_MUL : S_DIV;
                S_DIV: if (d_done) begin
                    r_op <= r_op + 3'd1; r_st <= S_LOAD;
                end
                S_MUL: r_st <= S_DONE;
                S_DONE: if (slot) begin
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- design/serial_stream_format_detector.sv -----
// ----------------------------------------------------------------------------
// serial_stream_format_detector
// classifies a sampled byte buffer as float framing, text lines or raw frames
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// input     in         i_push / o_full         i_in  (data_byte, last_byte)
// result    out        o_empty / i_pop         o_out (mode, confidence, ...)
// config    in         i_cfg_valid/o_cfg_ready i_cfg_data (min_bytes)
//
// one byte per cycle while the snapshot queue has room
// per buffer the back end runs four divisions on one shared restoring divider,
// then a multiply by one tenth and a verdict
// a waiting result holds the back end; a full two-entry queue then stalls i_push
// synchronous active-low reset; no clearing pass
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module serial_stream_format_detector #(
    parameter int MAX_BYTES     = 4096,
    parameter int FRACTION_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    output logic                             o_full,
    input  ssfd_pkg::t_in                    i_in,
    output logic                             o_empty,
    input  logic                             i_pop,
    output ssfd_pkg::t_out                   o_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ssfd_pkg::MIN_BYTES_W-1:0] i_cfg_data
);
    import ssfd_pkg::*;

    localparam int CW = $clog2(MAX_BYTES + 1);
    localparam int SW = 7 * CW + 2;

    logic [MIN_BYTES_W-1:0] r_min;
    t_q_wr                  q_wr;
    logic                   q_full, q_empty, q_pop;
    logic [SW-1:0]          snap_in, snap_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_min <= MIN_BYTES_RST;
        else if (i_cfg_valid) r_min <= i_cfg_data;
    end

    ssfd_front #(.MAX_BYTES(MAX_BYTES), .CW(CW), .SW(SW)) u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_in, .i_min_bytes(r_min),
        .o_q_wr(q_wr), .i_q_full(q_full), .o_snap(snap_in)
    );

    ssfd_queue #(.W(SW)) u_queue (
        .i_clk, .i_rst_n, .i_wr(q_wr), .i_data(snap_in), .o_full(q_full),
        .o_empty(q_empty), .i_pop(q_pop), .o_data(snap_out)
    );

    ssfd_back #(.CW(CW), .FB(FRACTION_BITS), .SW(SW)) u_back (
        .i_clk, .i_rst_n, .i_q_empty(q_empty), .o_q_pop(q_pop), .i_snap(snap_out),
        .o_empty, .i_pop, .o_out
    );

    `ASSERT_NEVER(a_no_push_when_full, i_clk, i_rst_n, q_wr.push && q_full, "push into full queue")
    `ASSERT_IMPL(a_result_held, i_clk, i_rst_n, !o_empty && !i_pop, ##1 !o_empty, "result dropped")
    `ASSERT_NEVER(a_pop_empty_queue, i_clk, i_rst_n, q_pop && q_empty, "pop from empty queue")
endmodule
